@@ rtl/fdef_pkg.sv @@
package fdef_pkg;

  localparam int unsigned CountBitsDefault = 16;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned TargetW   = 16;
  localparam int unsigned PosW      = 5;
  localparam int unsigned ClusterW  = 28;
  localparam int unsigned ClusHiW   = 12;
  localparam int unsigned ClusLoW   = 16;
  localparam int unsigned ApbAddrW  = 3;
  localparam int unsigned ApbDataW  = 32;

  localparam logic [ByteW-1:0] LeadDeleted  = 8'hE5;
  localparam logic [ByteW-1:0] LeadEnd      = 8'h00;
  localparam logic [ByteW-1:0] AttrSkipMask = 8'h0E;
  localparam logic [ByteW-1:0] AttrDir      = 8'h10;

  localparam logic [PosW-1:0] PosLead    = 5'd0;
  localparam logic [PosW-1:0] PosAttr    = 5'd11;
  localparam logic [PosW-1:0] PosHiLow   = 5'd20;
  localparam logic [PosW-1:0] PosHiHigh  = 5'd21;
  localparam logic [PosW-1:0] PosLoLow   = 5'd26;
  localparam logic [PosW-1:0] PosLoHigh  = 5'd27;
  localparam logic [PosW-1:0] PosLast    = 5'd31;

  localparam logic [0:0] RegFat32Mode = 1'b0;

  typedef struct packed {
    logic [ClusterW-1:0] start_cluster;
    logic                is_directory;
    logic                not_found;
  } result_t;

endpackage

@@ rtl/fat_directory_entry_finder.sv @@
// Scans a FAT directory region one byte per item, in 32-byte entries, and
// reports the start cluster and directory flag of the requested visible
// entry, or not found. A byte is taken in every cycle while in_stall_o is
// low; each item is handled in the cycle it is accepted and its result, if
// any, goes into the output register, or into the skid register behind it
// if that is full, so input keeps flowing while a result waits and stalls
// only when both hold a result that has not been taken. The fat32_mode
// register is at byte addresses 0-3 of the configuration port; resets to 1.
module fat_directory_entry_finder #(
  parameter int unsigned COUNT_BITS = fdef_pkg::CountBitsDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [fdef_pkg::ApbAddrW-1:0]  paddr,
  input  logic [fdef_pkg::ApbDataW-1:0]  pwdata,
  output logic [fdef_pkg::ApbDataW-1:0]  prdata,
  output logic                           pready,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [fdef_pkg::ByteW-1:0]     dir_byte_i,
  input  logic                           first_byte_i,
  input  logic                           last_byte_i,
  input  logic                           read_error_i,
  input  logic [fdef_pkg::TargetW-1:0]   target_entry_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [fdef_pkg::ClusterW-1:0]  start_cluster_o,
  output logic                           is_directory_o,
  output logic                           not_found_o
);

  localparam int unsigned CmpW =
    (COUNT_BITS > fdef_pkg::TargetW) ? COUNT_BITS : fdef_pkg::TargetW;
  localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};

  logic                              fat32_q;
  logic [fdef_pkg::PosW-1:0]         pos_q, pos_d;
  logic [COUNT_BITS-1:0]             count_q, count_d;
  logic [fdef_pkg::TargetW-1:0]      wanted_q, wanted_d;
  logic [fdef_pkg::ByteW-1:0]        lead_q, lead_d;
  logic [fdef_pkg::ByteW-1:0]        attr_q, attr_d;
  logic [fdef_pkg::ClusHiW-1:0]      hi_q, hi_d;
  logic [fdef_pkg::ClusLoW-1:0]      lo_q, lo_d;
  logic                              fin_q, fin_d;

  logic                              out_v_q, skid_v_q;
  fdef_pkg::result_t                 out_q, skid_q, res;

  logic                              cfg_sel, cfg_wr, in_acc, take, emit;
  logic                              visible, match;
  logic [COUNT_BITS-1:0]             count_inc;
  logic [fdef_pkg::ClusterW-1:0]     clus;

  assign cfg_sel = (paddr[fdef_pkg::ApbAddrW-1] == fdef_pkg::RegFat32Mode);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;
  assign prdata  = cfg_sel ? {{(fdef_pkg::ApbDataW-1){1'b0}}, fat32_q}
                           : '0;

  assign take       = out_v_q && !out_stall_i;
  assign in_stall_o = skid_v_q;
  assign in_acc     = in_valid_i && !skid_v_q;

  always_comb begin
    pos_d    = first_byte_i ? '0 : pos_q;
    count_d  = first_byte_i ? '0 : count_q;
    wanted_d = first_byte_i ? target_entry_i : wanted_q;
    lead_d   = first_byte_i ? '0 : lead_q;
    attr_d   = first_byte_i ? '0 : attr_q;
    hi_d     = first_byte_i ? '0 : hi_q;
    lo_d     = first_byte_i ? '0 : lo_q;
    fin_d    = first_byte_i ? 1'b0 : fin_q;
    emit     = 1'b0;
    visible  = 1'b0;
    match    = 1'b0;
    count_inc = '0;
    clus     = '0;
    res      = '{start_cluster: '0, is_directory: 1'b0, not_found: 1'b1};

    if (!fin_d) begin
      if (read_error_i) begin
        emit = 1'b1;
      end else begin
        case (pos_d)
          fdef_pkg::PosLead: begin
            lead_d = dir_byte_i;
          end
          fdef_pkg::PosAttr: begin
            attr_d = dir_byte_i;
          end
          fdef_pkg::PosHiLow: begin
            hi_d = {hi_d[fdef_pkg::ClusHiW-1:fdef_pkg::ByteW], dir_byte_i};
          end
          fdef_pkg::PosHiHigh: begin
            hi_d = {dir_byte_i[3:0], hi_d[fdef_pkg::ByteW-1:0]};
          end
          fdef_pkg::PosLoLow: begin
            lo_d = {lo_d[fdef_pkg::ClusLoW-1:fdef_pkg::ByteW], dir_byte_i};
          end
          fdef_pkg::PosLoHigh: begin
            lo_d = {dir_byte_i, lo_d[fdef_pkg::ByteW-1:0]};
          end
          default: begin
          end
        endcase

        visible = (pos_d == fdef_pkg::PosLast) &&
                  (lead_d != fdef_pkg::LeadDeleted) &&
                  ((attr_d & fdef_pkg::AttrSkipMask) == '0);
        count_inc = (count_d == CountMax) ? count_d : count_d + 1'b1;
        match = visible &&
                (CmpW'(count_inc) == CmpW'(wanted_d));
        clus = {(fat32_q ? hi_d : {fdef_pkg::ClusHiW{1'b0}}), lo_d};
        if (visible) begin
          count_d = count_inc;
        end

        if ((pos_d == fdef_pkg::PosLead) && (dir_byte_i == fdef_pkg::LeadEnd)) begin
          emit = 1'b1;
        end else if (match) begin
          emit = 1'b1;
          if ((clus != '0) || attr_d[4]) begin
            res.start_cluster = clus;
            res.is_directory  = |(attr_d & fdef_pkg::AttrDir);
            res.not_found     = 1'b0;
          end
        end else if (last_byte_i) begin
          emit = 1'b1;
        end
        pos_d = pos_d + 1'b1;
      end
    end
    if (emit) begin
      fin_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fat32_q  <= 1'b1;
      pos_q    <= '0;
      count_q  <= '0;
      wanted_q <= '0;
      lead_q   <= '0;
      attr_q   <= '0;
      hi_q     <= '0;
      lo_q     <= '0;
      fin_q    <= 1'b1;
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (cfg_wr && cfg_sel) begin
        fat32_q <= pwdata[0];
      end
      if (in_acc) begin
        pos_q    <= pos_d;
        count_q  <= count_d;
        wanted_q <= wanted_d;
        lead_q   <= lead_d;
        attr_q   <= attr_d;
        hi_q     <= hi_d;
        lo_q     <= lo_d;
        fin_q    <= fin_d;
      end
      if (!out_v_q || take) begin
        if (skid_v_q) begin
          out_v_q  <= 1'b1;
          skid_v_q <= 1'b0;
        end else begin
          out_v_q <= in_acc && emit;
        end
      end else if (in_acc && emit) begin
        skid_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || take) begin
      out_q <= skid_v_q ? skid_q : res;
    end else if (in_acc && emit) begin
      skid_q <= res;
    end
  end

  assign out_valid_o     = out_v_q;
  assign start_cluster_o = out_q.start_cluster;
  assign is_directory_o  = out_q.is_directory;
  assign not_found_o     = out_q.not_found;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid register holds a result while the output register is empty");

  a_skid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_v_q && !take) |=> (skid_v_q && $stable(skid_q)))
    else $error("waiting skid result was lost or changed");

  a_nf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_q.not_found) |->
      (out_q.start_cluster == '0 && !out_q.is_directory))
    else $error("not found result carries a cluster or directory flag");

  a_found_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_q.not_found) |->
      (out_q.start_cluster != '0 || out_q.is_directory))
    else $error("found result has zero cluster and no directory flag");

  a_result_ends_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && emit) |=> fin_q)
    else $error("scan still running after a result");

endmodule
